FILE: rtl/core/mhu_pkg.sv
// shared widths, constants, register indexes and the cordic angle table
// for the magnetometer heading unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mhu_pkg;

  // ring and sample widths
  localparam int unsigned XY_W          = 13;
  localparam int unsigned Z_W           = 15;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned RAW_W         = 16;
  localparam int unsigned DROP_W        = 3;
  localparam int unsigned DEPTH_DEFAULT = 5;

  // result widths
  localparam int unsigned XY_AVG_W = 17;
  localparam int unsigned Z_AVG_W  = 19;
  localparam int unsigned HEAD_W   = 16;
  localparam int unsigned FRAC_W   = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_XY_DROP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_DROP  = 2'd1;
  localparam logic [DROP_W-1:0] XY_DROP_RESET = 3'd3;
  localparam logic [DROP_W-1:0] Z_DROP_RESET  = 3'd1;

  // cordic datapath
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W       = 4;
  localparam int unsigned CA_W         = 28;
  localparam int unsigned CZ_W         = 25;
  localparam int unsigned PRE_SHIFT    = 8;
  localparam logic signed [CZ_W-1:0] CZ_QUARTER = 25'sd2304000;
  localparam logic signed [CZ_W-1:0] CZ_ROUND   = 25'sd128;
  localparam logic signed [CZ_W-1:0] HEAD_MAX   = 25'sd18000;
  localparam logic signed [CZ_W-1:0] HEAD_MIN   = -25'sd18000;

  // atan(2^-i) in 1/256 hundredths of a degree
  function automatic logic signed [CZ_W-1:0] cordic_angle(input logic [STEP_W-1:0] step);
    logic signed [CZ_W-1:0] ang;
    case (step)
      4'd0:    ang = 25'sd1152000;
      4'd1:    ang = 25'sd680065;
      4'd2:    ang = 25'sd359328;
      4'd3:    ang = 25'sd182400;
      4'd4:    ang = 25'sd91554;
      4'd5:    ang = 25'sd45822;
      4'd6:    ang = 25'sd22916;
      4'd7:    ang = 25'sd11459;
      4'd8:    ang = 25'sd5730;
      4'd9:    ang = 25'sd2865;
      4'd10:   ang = 25'sd1432;
      4'd11:   ang = 25'sd716;
      4'd12:   ang = 25'sd358;
      4'd13:   ang = 25'sd179;
      4'd14:   ang = 25'sd90;
      4'd15:   ang = 25'sd45;
      default: ang = '0;
    endcase
    return ang;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/magnetometer_heading_unit.sv
// averaging compass: sample ring, running sums, shared divider and cordic
// depends on mhu_pkg, mhu_axis_unpack, mhu_divider, mhu_cordic
// a sample without a report request is stored and the unit stays idle; the next can follow at once
// a report is valid, and the input free again, once its transfer has passed three
// reciprocal divides, one cordic run and the output load; a full output
// register holds the sequencer; reset clears ring, sums, slot, drops to 3 (x/y), 1 (z)
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_heading_unit import mhu_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DROP_W-1:0]    cfg_data_i,

  // sample channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    x_low_byte_i,
  input  wire logic [BYTE_W-1:0]    x_high_byte_i,
  input  wire logic [BYTE_W-1:0]    y_low_byte_i,
  input  wire logic [BYTE_W-1:0]    y_high_byte_i,
  input  wire logic [BYTE_W-1:0]    z_low_byte_i,
  input  wire logic [BYTE_W-1:0]    z_high_byte_i,
  input  wire logic                 report_now_i,

  // report channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [XY_AVG_W-1:0] x_average_o,
  output logic signed [XY_AVG_W-1:0] y_average_o,
  output logic signed [Z_AVG_W-1:0]  z_average_o,
  output logic signed [HEAD_W-1:0]   heading_o
);

  // widths that follow from the ring depth
  localparam int unsigned SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUM_XY_W = XY_W + $clog2(DEPTH);
  localparam int unsigned SUM_Z_W  = Z_W + $clog2(DEPTH);
  localparam int unsigned DIV_W    = SUM_Z_W + FRAC_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_GO   = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT = 3'd2;
  localparam logic [2:0] ST_COR_GO   = 3'd3;
  localparam logic [2:0] ST_COR_WAIT = 3'd4;
  localparam logic [2:0] ST_OUT      = 3'd5;

  // axis being divided
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       neg_q, neg_d;

  // configuration registers
  logic [DROP_W-1:0] xy_drop_q, z_drop_q;

  // ring and running sums
  logic signed [XY_W-1:0]     x_ring_q [DEPTH];
  logic signed [XY_W-1:0]     y_ring_q [DEPTH];
  logic signed [Z_W-1:0]      z_ring_q [DEPTH];
  logic [SLOT_W-1:0]          slot_q;
  logic signed [SUM_XY_W-1:0] x_total_q, x_total_d;
  logic signed [SUM_XY_W-1:0] y_total_q, y_total_d;
  logic signed [SUM_Z_W-1:0]  z_total_q, z_total_d;

  // assembled samples of the incoming transfer
  logic signed [XY_W-1:0] x_smp, y_smp;
  logic signed [Z_W-1:0]  z_smp;

  // means and result registers
  logic signed [XY_AVG_W-1:0] x_mean_q, y_mean_q;
  logic signed [Z_AVG_W-1:0]  z_mean_q;
  logic signed [HEAD_W-1:0]   head_q;
  logic                       out_valid_q;
  logic signed [XY_AVG_W-1:0] x_avg_q, y_avg_q;
  logic signed [Z_AVG_W-1:0]  z_avg_q;
  logic signed [HEAD_W-1:0]   head_out_q;

  // shared unit hookup
  logic                      div_start, div_done;
  logic [DIV_W-1:0]          div_quot;
  logic [DIV_W-1:0]          div_dividend;
  logic signed [SUM_Z_W-1:0] sel_total;
  logic [SUM_Z_W-1:0]        sel_mag;
  logic [DIV_W-1:0]          quot_signed;
  logic                      cor_start, cor_done;
  logic signed [HEAD_W-1:0]  cor_heading;

  logic in_xfer, out_xfer, out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_xfer    = out_valid_q & out_ready_i;
  assign out_load    = (state_q == ST_OUT) & (~out_valid_q | out_ready_i);

  mhu_axis_unpack #(.OUT_W(XY_W)) u_unpack_x (
    .low_byte_i  (x_low_byte_i),
    .high_byte_i (x_high_byte_i),
    .drop_i      (xy_drop_q),
    .sample_o    (x_smp)
  );

  mhu_axis_unpack #(.OUT_W(XY_W)) u_unpack_y (
    .low_byte_i  (y_low_byte_i),
    .high_byte_i (y_high_byte_i),
    .drop_i      (xy_drop_q),
    .sample_o    (y_smp)
  );

  mhu_axis_unpack #(.OUT_W(Z_W)) u_unpack_z (
    .low_byte_i  (z_low_byte_i),
    .high_byte_i (z_high_byte_i),
    .drop_i      (z_drop_q),
    .sample_o    (z_smp)
  );

  // running sums: add the new sample, drop the one it overwrites
  always_comb begin
    x_total_d = x_total_q + SUM_XY_W'(x_smp) - SUM_XY_W'(x_ring_q[slot_q]);
    y_total_d = y_total_q + SUM_XY_W'(y_smp) - SUM_XY_W'(y_ring_q[slot_q]);
    z_total_d = z_total_q + SUM_Z_W'(z_smp) - SUM_Z_W'(z_ring_q[slot_q]);
  end

  // divider operand: magnitude of the selected sum, scaled to q.4
  always_comb begin
    case (axis_q)
      AXIS_X:  sel_total = SUM_Z_W'(x_total_q);
      AXIS_Y:  sel_total = SUM_Z_W'(y_total_q);
      AXIS_Z:  sel_total = z_total_q;
      default: sel_total = '0;
    endcase
    sel_mag      = sel_total[SUM_Z_W-1] ? (~sel_total + 1'b1) : sel_total;
    div_dividend = {sel_mag, {FRAC_W{1'b0}}};
    // quotient of the magnitude, sign put back: truncation toward zero
    quot_signed  = neg_q ? (~div_quot + 1'b1) : div_quot;
  end

  mhu_divider #(.DEPTH(DEPTH), .DIV_W(DIV_W)) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  mhu_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cor_start),
    .x_mean_i  (x_mean_q),
    .y_mean_i  (y_mean_q),
    .done_o    (cor_done),
    .heading_o (cor_heading)
  );

  // sequencer: three divider runs, then one cordic run, then the result
  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    neg_d     = neg_q;
    div_start = 1'b0;
    cor_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && report_now_i) begin
          state_d = ST_DIV_GO;
          axis_d  = AXIS_X;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        neg_d     = sel_total[SUM_Z_W-1];
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (axis_q == AXIS_Z) begin
            state_d = ST_COR_GO;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_COR_GO: begin
        cor_start = 1'b1;
        state_d   = ST_COR_WAIT;
      end
      ST_COR_WAIT: begin
        if (cor_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_X;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      xy_drop_q   <= XY_DROP_RESET;
      z_drop_q    <= Z_DROP_RESET;
      slot_q      <= '0;
      x_total_q   <= '0;
      y_total_q   <= '0;
      z_total_q   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        x_ring_q[i] <= '0;
        y_ring_q[i] <= '0;
        z_ring_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      neg_q   <= neg_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_XY_DROP: xy_drop_q <= cfg_data_i;
          REG_Z_DROP:  z_drop_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // store the sample and advance the write slot
      if (in_xfer) begin
        x_ring_q[slot_q] <= x_smp;
        y_ring_q[slot_q] <= y_smp;
        z_ring_q[slot_q] <= z_smp;
        x_total_q        <= x_total_d;
        y_total_q        <= y_total_d;
        z_total_q        <= z_total_d;
        slot_q           <= (slot_q == SLOT_W'(DEPTH-1)) ? '0 : slot_q + 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_WAIT && div_done) begin
      case (axis_q)
        AXIS_X:  x_mean_q <= quot_signed[XY_AVG_W-1:0];
        AXIS_Y:  y_mean_q <= quot_signed[XY_AVG_W-1:0];
        AXIS_Z:  z_mean_q <= quot_signed[Z_AVG_W-1:0];
        default: ;
      endcase
    end
    if (state_q == ST_COR_WAIT && cor_done) begin
      head_q <= cor_heading;
    end
    if (out_load) begin
      x_avg_q    <= x_mean_q;
      y_avg_q    <= y_mean_q;
      z_avg_q    <= z_mean_q;
      head_out_q <= head_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_average_o = x_avg_q;
  assign y_average_o = y_avg_q;
  assign z_average_o = z_avg_q;
  assign heading_o   = head_out_q;

endmodule

`default_nettype wire

FILE: rtl/core/mhu_axis_unpack.sv
// one axis: builds the signed sample from two register bytes, shifting out drop_i low bits and saturating to OUT_W
// depends on mhu_pkg
`timescale 1ns / 1ps
`default_nettype none

module mhu_axis_unpack import mhu_pkg::*; #(
  parameter int unsigned OUT_W = XY_W
) (
  input  wire logic [BYTE_W-1:0]      low_byte_i,
  input  wire logic [BYTE_W-1:0]      high_byte_i,
  input  wire logic [DROP_W-1:0]      drop_i,
  output logic signed [OUT_W-1:0]     sample_o
);

  localparam logic signed [RAW_W-1:0] MAX_V = RAW_W'((32'sd1 <<< (OUT_W-1)) - 32'sd1);
  localparam logic signed [RAW_W-1:0] MIN_V = -MAX_V - 16'sd1;

  logic [BYTE_W-1:0]       low_mask;
  logic signed [RAW_W-1:0] raw;
  logic signed [RAW_W-1:0] shifted;

  always_comb begin
    low_mask = {BYTE_W{1'b1}} << drop_i;
    raw      = $signed({high_byte_i, low_byte_i & low_mask});
    shifted  = raw >>> drop_i;
    if (shifted > MAX_V) begin
      sample_o = MAX_V[OUT_W-1:0];
    end else if (shifted < MIN_V) begin
      sample_o = MIN_V[OUT_W-1:0];
    end else begin
      sample_o = shifted[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mhu_divider.sv
// division by the ring depth as a multiply by the rounded-up reciprocal,
// quotient and done registered in the cycle after start; depends on mhu_pkg
`timescale 1ns / 1ps
`default_nettype none

module mhu_divider import mhu_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned DIV_W = 22
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);

  // floor(n / DEPTH) == floor(n * RECIP / 2^SHIFT) for every DIV_W-bit n
  localparam int unsigned LOG_D  = $clog2(DEPTH);
  localparam int unsigned SHIFT  = DIV_W + LOG_D;
  localparam int unsigned REC_W  = DIV_W + 1;
  localparam int unsigned PROD_W = DIV_W + REC_W;
  localparam logic [REC_W-1:0] RECIP =
    REC_W'(((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  logic              done_q;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  quot_d, quot_q;

  always_comb begin
    prod   = PROD_W'(dividend_i) * PROD_W'(RECIP);
    quot_d = DIV_W'(prod >> SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= quot_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire

FILE: rtl/core/mhu_cordic.sv
// iterative vectoring cordic, one micro-rotation per cycle, gives atan2(x, y)
// in hundredths of a degree; depends on mhu_pkg
`timescale 1ns / 1ps
`default_nettype none

module mhu_cordic import mhu_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [XY_AVG_W-1:0] x_mean_i,
  input  wire logic signed [XY_AVG_W-1:0] y_mean_i,
  output logic                        done_o,
  output logic signed [HEAD_W-1:0]    heading_o
);

  localparam int unsigned EXT_W = CA_W - XY_AVG_W - PRE_SHIFT;

  logic                    busy_q, busy_d;
  logic                    fin_q, fin_d;
  logic                    done_q, done_d;
  logic                    zero_q, zero_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic signed [CA_W-1:0]  a_q, a_d, b_q, b_d;
  logic signed [CZ_W-1:0]  z_q, z_d;
  logic signed [HEAD_W-1:0] head_q, head_d;

  logic signed [CA_W-1:0]  a0, b0, da, db;
  logic signed [CZ_W-1:0]  z_round;

  always_comb begin
    a0 = $signed({{EXT_W{y_mean_i[XY_AVG_W-1]}}, y_mean_i, {PRE_SHIFT{1'b0}}});
    b0 = $signed({{EXT_W{x_mean_i[XY_AVG_W-1]}}, x_mean_i, {PRE_SHIFT{1'b0}}});
    da = b_q >>> step_q;
    db = a_q >>> step_q;
    z_round = (z_q + CZ_ROUND) >>> PRE_SHIFT;

    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    zero_d = zero_q;
    step_d = step_q;
    a_d    = a_q;
    b_d    = b_q;
    z_d    = z_q;
    head_d = head_q;

    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      zero_d = (x_mean_i == '0) && (y_mean_i == '0);
      // negative y half plane: turn by a quarter first
      if (a0[CA_W-1] && !b0[CA_W-1]) begin
        a_d = b0;
        b_d = -a0;
        z_d = CZ_QUARTER;
      end else if (a0[CA_W-1]) begin
        a_d = -b0;
        b_d = a0;
        z_d = -CZ_QUARTER;
      end else begin
        a_d = a0;
        b_d = b0;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (!b_q[CA_W-1]) begin
        a_d = a_q + da;
        b_d = b_q - db;
        z_d = z_q + cordic_angle(step_q);
      end else begin
        a_d = a_q - da;
        b_d = b_q + db;
        z_d = z_q - cordic_angle(step_q);
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(CORDIC_STEPS-1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      // round half up to hundredths, then clamp; a zero vector gives heading 0
      done_d = 1'b1;
      if (zero_q) begin
        head_d = '0;
      end else if (z_round > HEAD_MAX) begin
        head_d = HEAD_MAX[HEAD_W-1:0];
      end else if (z_round < HEAD_MIN) begin
        head_d = HEAD_MIN[HEAD_W-1:0];
      end else begin
        head_d = z_round[HEAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    a_q    <= a_d;
    b_q    <= b_d;
    z_q    <= z_d;
    head_q <= head_d;
  end

  assign done_o    = done_q;
  assign heading_o = head_q;

endmodule

`default_nettype wire
